/* design/grs_pkg.sv */
// Shared types and constants for the group reverse stream block.
`default_nettype none
package grs_pkg;

    localparam int MAX_GROUP  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int CFG_W      = 7;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [CFG_W-1:0]             t_cfg;

    // Shift command broadcast to every cell of the stack.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

/* design/grs_cell.sv */
// One storage cell of the shift stack: takes its older neighbor on pop, newer on push.
`default_nettype none
module grs_cell (
    input  wire                 i_clk,
    input  grs_pkg::t_shift_ctl i_ctl,
    input  grs_pkg::t_data      i_prev_data,
    input  grs_pkg::t_data      i_next_data,
    output grs_pkg::t_data      o_data
);
    import grs_pkg::*;

    t_data r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_prev_data;
        end else if (i_ctl.pop) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

/* design/grs_ctrl.sv */
// Fill/drain sequencer and output register of the group reverse stream.
`default_nettype none
module grs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  grs_pkg::t_cfg       i_group_size,
    input  wire                 i_s_tvalid,
    input  wire                 i_s_tlast,
    output logic                o_s_tready,
    input  grs_pkg::t_data      i_top_data,
    output grs_pkg::t_shift_ctl o_ctl,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output grs_pkg::t_data      o_m_data,
    output logic                o_m_group_last,
    output logic                o_m_seq_last
);
    import grs_pkg::*;

    t_state r_state, n_state;
    t_count r_fill, n_fill;
    t_count r_remain, n_remain;
    logic   r_seq_end, n_seq_end;
    logic   r_out_valid, n_out_valid;
    t_data  r_out_data;
    logic   r_out_glast;
    logic   r_out_slast;

    t_count w_k;
    t_count w_fill_inc;
    logic   w_push;
    logic   w_load;

    // Group size zero acts as one; sizes above the stack depth saturate.
    always_comb begin
        if (i_group_size == '0) begin
            w_k = t_count'(1);
        end else if (32'(i_group_size) > 32'(MAX_GROUP)) begin
            w_k = t_count'(MAX_GROUP);
        end else begin
            w_k = t_count'(i_group_size);
        end
    end

    assign w_fill_inc = r_fill + t_count'(1);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_remain    = r_remain;
        n_seq_end   = r_seq_end;
        o_s_tready  = 1'b0;
        w_push      = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_FILL: begin
                o_s_tready = 1'b1;
                w_push     = i_s_tvalid;
                if (i_s_tvalid) begin
                    if (w_fill_inc >= w_k || i_s_tlast) begin
                        n_fill    = '0;
                        n_remain  = w_fill_inc;
                        n_seq_end = i_s_tlast;
                        n_state   = ST_DRAIN;
                    end else begin
                        n_fill = w_fill_inc;
                    end
                end
            end
            ST_DRAIN: begin
                w_load = !r_out_valid || i_m_tready;
                if (w_load) begin
                    n_remain = r_remain - t_count'(1);
                    if (r_remain == t_count'(1)) begin
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill      <= '0;
            r_remain    <= '0;
            r_seq_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_remain    <= n_remain;
            r_seq_end   <= n_seq_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data  <= i_top_data;
            r_out_glast <= (r_remain == t_count'(1));
            r_out_slast <= (r_remain == t_count'(1)) && r_seq_end;
        end
    end

    assign o_ctl.push     = w_push;
    assign o_ctl.pop      = w_load;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_data       = r_out_data;
    assign o_m_group_last = r_out_glast;
    assign o_m_seq_last   = r_out_slast;

endmodule
`default_nettype wire

/* design/group_reverse_stream.sv */
// Top level of the group reverse stream: config register, cell stack, sequencer.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------------
//  s       | in        | i_s_tvalid / o_s_tready  | tdata element_value, tlast seq end
//  m       | out       | o_m_tvalid / i_m_tready  | tdata out_value, tlast group_last,
//          |           |                          | tuser sequence_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready| group_size (7 bits)
//
// Each element is pushed into the cell stack when it is accepted and popped out when the output
// register loads; input is held off while a group drains.
// The stack is a row of MAX_GROUP cells that all shift together on push or pop.
// Reset is synchronous, active low, and sets group_size to 1 with the stack empty.
// A stalled output holds its result while the next one waits in the stack.
`default_nettype none
module group_reverse_stream (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  grs_pkg::t_data      i_s_tdata,   // [31:0] element_value
    input  wire                 i_s_tlast,   // sequence_end
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output grs_pkg::t_data      o_m_tdata,   // [31:0] out_value
    output logic                o_m_tlast,   // group_last
    output logic                o_m_tuser,   // [0] sequence_last
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  grs_pkg::t_cfg       i_cfg_data
);
    import grs_pkg::*;

    t_cfg       r_group_size;
    t_shift_ctl w_ctl;
    t_data      w_cell_data [MAX_GROUP];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= t_cfg'(1);
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_data;
        end
    end

    // Cell 0 holds the newest element; pushes move data toward the deep end.
    for (genvar g = 0; g < MAX_GROUP; g++) begin : g_cell
        t_data w_prev;
        t_data w_next;
        if (g == 0) begin : g_head
            assign w_prev = i_s_tdata;
        end else begin : g_body
            assign w_prev = w_cell_data[g-1];
        end
        if (g == MAX_GROUP - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_cell_data[g+1];
        end
        grs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .o_data      (w_cell_data[g])
        );
    end

    grs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_group_size   (r_group_size),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tlast      (i_s_tlast),
        .o_s_tready     (o_s_tready),
        .i_top_data     (w_cell_data[0]),
        .o_ctl          (w_ctl),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_data       (o_m_tdata),
        .o_m_group_last (o_m_tlast),
        .o_m_seq_last   (o_m_tuser)
    );

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.push && w_ctl.pop))
        else $error("stack pushed and popped in the same cycle");

    a_pop_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> !o_s_tready)
        else $error("input accepted while a group drains");

    a_end_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("sequence end did not close the group");

    a_seq_last_on_group_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("sequence end flagged on a result that does not close a group");

endmodule
`default_nettype wire

/* tb/group_reverse_stream_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the group reverse stream block.
module group_reverse_stream_tb;
    import grs_pkg::*;

    localparam int NUM_ITEMS     = 350;
    localparam int QUIET_AFTER   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_BIG_SETS  = 3;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ELEM,
        ROW_ELEM_TYPED
    } t_row_kind;

    typedef struct packed {
        t_data value;
        logic  group_last;
        logic  seq_last;
    } t_rev_word;

    typedef struct packed {
        t_row_kind kind;
        t_cfg      size;
        t_data     value;
        logic      last;
        t_data     exp_value;
        logic      exp_glast;
        logic      exp_slast;
    } t_row;

    // Typed expectations only where each group holds a single word, so each word comes straight back.
    localparam int NUM_ROWS = 27;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_ELEM_TYPED, 7'd0,   32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0},
        '{ROW_ELEM_TYPED, 7'd0,   32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b1},
        '{ROW_ELEM_TYPED, 7'd0,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, 1'b0},
        '{ROW_ELEM_TYPED, 7'd0,   32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{ROW_CFG,        7'd0,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM_TYPED, 7'd0,   32'h5555_5555, 1'b1, 32'h5555_5555, 1'b1, 1'b1},
        '{ROW_CFG,        7'd3,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd1,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd2,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd3,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd4,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd5,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd6,         1'b1, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd7,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd8,         1'b1, 32'h0,         1'b0, 1'b0},
        '{ROW_CFG,        7'd127, 32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM_TYPED, 7'd0,   32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1'b1, 1'b1},
        '{ROW_CFG,        7'd5,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd9,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd10,        1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd11,        1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd12,        1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_CFG,        7'd2,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd13,        1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_CFG,        7'd64,  32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'h0F0F_F0F0, 1'b0, 32'h0,         1'b0, 1'b0},
        '{ROW_ELEM,       7'd0,   32'd14,        1'b1, 32'h0,         1'b0, 1'b0}
    };

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_s_tvalid  = 1'b0;
    t_data i_s_tdata   = '0;
    logic  i_s_tlast   = 1'b0;
    logic  i_m_tready  = 1'b0;
    logic  i_cfg_valid = 1'b0;
    t_cfg  i_cfg_data  = '0;
    logic  o_s_tready;
    logic  o_m_tvalid;
    t_data o_m_tdata;
    logic  o_m_tlast;
    logic  o_m_tuser;
    logic  o_cfg_ready;

    // Predictor state: the configured size and the words of the group being filled.
    t_cfg      held_size = 7'd1;
    t_data     held_words [$];
    t_rev_word expected_words [$];

    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int stall_left     = 0;
    int fail_count     = 0;
    int items_sent     = 0;
    int words_checked  = 0;
    int cfg_writes     = 0;
    int cycle_count    = 0;

    group_reverse_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [31:0] element_value
        .i_s_tlast   (i_s_tlast),   // sequence_end
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [31:0] out_value
        .o_m_tlast   (o_m_tlast),   // group_last
        .o_m_tuser   (o_m_tuser),   // [0] sequence_last
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Zero behaves as one and anything above the buffer depth saturates.
    function automatic int group_limit(input t_cfg size);
        if (size == 0) begin
            return 1;
        end
        return (size > MAX_GROUP) ? MAX_GROUP : int'(size);
    endfunction

    function automatic void predict_reversal(input t_data value, input logic last,
                                             ref t_rev_word words [$]);
        int        n;
        t_rev_word w;
        held_words.push_back(value);
        if (held_words.size() < group_limit(held_size) && !last) begin
            return;
        end
        n = held_words.size();
        for (int i = n - 1; i >= 0; i--) begin
            w.value      = held_words[i];
            w.group_last = (i == 0);
            w.seq_last   = (i == 0) && last;
            words.push_back(w);
        end
        held_words.delete();
    endfunction

    function automatic t_data random_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_element(input t_data value, input logic last, input bit typed,
                                input t_rev_word typed_word);
        t_rev_word produced [$];
        int        gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        predict_reversal(value, last, produced);
        if (typed) begin
            expected_words.push_back(typed_word);
        end else begin
            foreach (produced[i]) expected_words.push_back(produced[i]);
        end
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A word that closes no group may still be entering the stack, hence the settle time.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_group_size(input t_cfg size);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        held_size = size;
        cfg_writes++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_rev_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("Unexpected word %h glast %b slast %b at cycle %0d",
                             o_m_tdata, o_m_tlast, o_m_tuser, cycle_count);
                end
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (o_m_tdata !== want.value || o_m_tlast !== want.group_last ||
                    o_m_tuser !== want.seq_last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("Mismatch at cycle %0d: expected %h/%b/%b, got %h/%b/%b",
                                 cycle_count, want.value, want.group_last, want.seq_last,
                                 o_m_tdata, o_m_tlast, o_m_tuser);
                    end
                end
            end
        end
        if (sink_stalls_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8);
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still outstanding",
                     cycle_count, expected_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_row      row;
        t_rev_word typed_word;
        t_cfg      size;
        int        eff;
        int        big_sets;
        int        phase_items;
        int        seq_len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CFG) begin
                write_group_size(row.size);
            end else begin
                typed_word.value      = row.exp_value;
                typed_word.group_last = row.exp_glast;
                typed_word.seq_last   = row.exp_slast;
                send_element(row.value, row.last, row.kind == ROW_ELEM_TYPED, typed_word);
            end
        end

        // Random phases: mostly short groups, a few large or saturated ones.
        big_sets = 0;
        while (items_sent < NUM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       size = 7'd0;
                1:       size = 7'd64;
                2:       size = t_cfg'($urandom_range(65, 127));
                3:       size = t_cfg'($urandom_range(9, 63));
                default: size = t_cfg'($urandom_range(1, 8));
            endcase
            if (group_limit(size) > 8) begin
                if (big_sets >= MAX_BIG_SETS) begin
                    size = t_cfg'($urandom_range(1, 8));
                end else begin
                    big_sets++;
                end
            end
            write_group_size(size);
            eff = group_limit(size);
            phase_items = (eff > 8) ? eff + $urandom_range(0, eff) : $urandom_range(15, 40);
            // A phase may stop inside a group, so the next size change lands mid-group.
            while (phase_items > 0 && items_sent < NUM_ITEMS) begin
                seq_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 3 * eff);
                for (int j = 0; j < seq_len; j++) begin
                    if (phase_items == 0 || items_sent >= NUM_ITEMS) begin
                        break;
                    end
                    send_element(random_word(), j == seq_len - 1, 1'b0, '0);
                    phase_items--;
                    if (items_sent >= QUIET_AFTER) begin
                        src_gaps_on    = 1'b0;
                        sink_stalls_on = 1'b0;
                    end
                end
            end
        end
        send_element(random_word(), 1'b1, 1'b0, '0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d elements over %0d group size writes, checked %0d reversed words.",
                 items_sent, cfg_writes, words_checked);
        $display("Sizes included zero, one, 64 and saturated values; %0d failures seen.",
                 fail_count + expected_words.size());
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* group_reverse_stream.f */
design/grs_pkg.sv
design/grs_cell.sv
design/grs_ctrl.sv
design/group_reverse_stream.sv
tb/group_reverse_stream_tb.sv
